>>> rtl/efud_pkg.sv
// Package with the parser state, result kinds and framing characters of the deframer.
`timescale 1ns / 1ps

package efud_pkg;

    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_START = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;

    localparam int unsigned KIND_W  = 3;
    localparam int unsigned VALUE_W = 8;
    localparam int unsigned INDEX_W = 5;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_ESC   = 3'd1,
        ST_CID   = 3'd2,
        ST_ADDR  = 3'd3,
        ST_PORT  = 3'd4,
        ST_DATA  = 3'd5,
        ST_CLOSE = 3'd6,
        ST_SKIP  = 3'd7
    } t_parse_state;

    typedef enum logic [KIND_W-1:0] {
        KIND_CID       = 3'd0,
        KIND_ADDR_CHAR = 3'd1,
        KIND_ADDR_END  = 3'd2,
        KIND_PORT_CHAR = 3'd3,
        KIND_PORT_END  = 3'd4,
        KIND_DATA_CHAR = 3'd5,
        KIND_DONE      = 3'd6
    } t_item_kind;

endpackage

>>> rtl/escape_framed_udp_deframer.sv
// Top level of the escape-framed UDP deframer: byte register, parser and result register.
`timescale 1ns / 1ps

// Parses frames of the form ESC 'u' CID ADDRESS SPACE PORT TAB DATA ESC x, one received
// byte per word, and reports the channel id, each address, port and data character with
// its position in the field, the end of each field with its length, and frame completion.
// A byte is registered when accepted and is parsed in the following cycle; its result is
// registered when the byte advances, held off while a stalled result waits. One byte is
// taken in every cycle as long as the result register drains; a byte that yields no result
// is consumed even while a result waits. Positions saturate at SMALL_LEN-1. Bytes from 128
// to 255 count as printable only while the configuration bit is set; write it only while
// the block is idle.
module escape_framed_udp_deframer #(
    parameter int unsigned SMALL_LEN = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [efud_pkg::VALUE_W-1:0] i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [efud_pkg::KIND_W-1:0]  o_item_kind,
    output logic [efud_pkg::VALUE_W-1:0] o_item_value,
    output logic [efud_pkg::INDEX_W-1:0] o_item_index
);
    import efud_pkg::*;

    localparam int unsigned IDX_W = (SMALL_LEN > 2) ? $clog2(SMALL_LEN) : 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SMALL_LEN - 1);

    t_parse_state       r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx, idx_bump;
    logic               r_accept_high;
    logic               r_in_valid;
    logic [VALUE_W-1:0] r_in_byte;
    logic               r_out_valid;
    t_item_kind         r_kind, n_kind;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [INDEX_W-1:0] r_index, n_index;
    logic               res_valid;
    logic               printable;
    logic               advance;
    logic               in_accept;

    assign printable = r_in_byte[VALUE_W-1] ? r_accept_high : (r_in_byte >= CH_SPACE);
    assign idx_bump  = (r_idx == IDX_MAX) ? r_idx : r_idx + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        res_valid = 1'b0;
        n_kind    = KIND_CID;
        n_value   = '0;
        n_index   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (r_in_byte == CH_ESC) begin
                    n_state = ST_ESC;
                end
            end
            ST_ESC: begin
                n_state = (r_in_byte == CH_START) ? ST_CID : ST_SKIP;
            end
            ST_CID: begin
                n_idx     = '0;
                n_state   = ST_ADDR;
                res_valid = 1'b1;
                n_kind    = KIND_CID;
                n_value   = r_in_byte;
            end
            ST_ADDR: begin
                priority if (r_in_byte == CH_ESC) begin
                    n_state = ST_IDLE;
                end else if (r_in_byte == CH_SPACE) begin
                    res_valid = 1'b1;
                    n_kind    = KIND_ADDR_END;
                    n_index   = INDEX_W'(r_idx);
                    n_idx     = '0;
                    n_state   = ST_PORT;
                end else if (printable) begin
                    res_valid = 1'b1;
                    n_kind    = KIND_ADDR_CHAR;
                    n_value   = r_in_byte;
                    n_index   = INDEX_W'(r_idx);
                    n_idx     = idx_bump;
                end else begin
                    n_state = r_state;
                end
            end
            ST_PORT: begin
                priority if (r_in_byte == CH_ESC) begin
                    n_state = ST_IDLE;
                end else if (r_in_byte == CH_TAB) begin
                    res_valid = 1'b1;
                    n_kind    = KIND_PORT_END;
                    n_index   = INDEX_W'(r_idx);
                    n_idx     = '0;
                    n_state   = ST_DATA;
                end else if (printable) begin
                    res_valid = 1'b1;
                    n_kind    = KIND_PORT_CHAR;
                    n_value   = r_in_byte;
                    n_index   = INDEX_W'(r_idx);
                    n_idx     = idx_bump;
                end else begin
                    n_state = r_state;
                end
            end
            ST_DATA: begin
                priority if (r_in_byte == CH_ESC) begin
                    n_state = ST_CLOSE;
                end else if (printable) begin
                    res_valid = 1'b1;
                    n_kind    = KIND_DATA_CHAR;
                    n_value   = r_in_byte;
                    n_index   = INDEX_W'(r_idx);
                    n_idx     = idx_bump;
                end else begin
                    n_state = r_state;
                end
            end
            ST_CLOSE: begin
                res_valid = 1'b1;
                n_kind    = KIND_DONE;
                n_index   = INDEX_W'(r_idx);
                n_state   = ST_IDLE;
            end
            ST_SKIP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A byte without a result never waits for the result register.
    assign advance    = r_in_valid && (!res_valid || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx         <= '0;
            r_accept_high <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (advance) begin
                r_idx <= n_idx;
            end
            if (i_cfg_wr_en) begin
                r_accept_high <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance && res_valid) begin
            r_kind  <= n_kind;
            r_value <= n_value;
            r_index <= n_index;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_item_kind  = r_kind;
    assign o_item_value = r_value;
    assign o_item_index = r_index;

endmodule

>>> rtl/efud_checker.sv
// Port checker for the deframer and the bind that attaches it to the top level.
`timescale 1ns / 1ps

module efud_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [efud_pkg::KIND_W-1:0]  o_item_kind,
    input logic [efud_pkg::VALUE_W-1:0] o_item_value,
    input logic [efud_pkg::INDEX_W-1:0] o_item_index
);
    import efud_pkg::*;

    // No result word is offered in the cycle after reset.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result word offered right after reset");

    // A stalled result word holds until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_item_kind)
            && $stable(o_item_value) && $stable(o_item_index))
        else $error("stalled result word changed");

    // Field ends and frame completion carry no character.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_item_kind == KIND_ADDR_END || o_item_kind == KIND_PORT_END
            || o_item_kind == KIND_DONE) |-> o_item_value == '0)
        else $error("end word carries a character");

    // The channel id carries position zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_item_kind == KIND_CID |-> o_item_index == '0)
        else $error("channel id word with nonzero position");

    // The unused kind code never appears.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_item_kind != 3'd7)
        else $error("undefined result kind");

endmodule

bind escape_framed_udp_deframer efud_checker u_efud_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_item_kind  (o_item_kind),
    .o_item_value (o_item_value),
    .o_item_index (o_item_index)
);

>>> verif/escape_framed_udp_deframer_tb.sv
// Self-checking testbench for the escape-framed UDP deframer, with a built-in frame parser model.
`timescale 1ns / 1ps

module escape_framed_udp_deframer_tb;
    import efud_pkg::*;

    localparam int unsigned SMALL_LEN    = 32;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct {
        t_item_kind         kind;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } t_parsed_item;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic               i_cfg_wr_data = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [VALUE_W-1:0] i_rx_byte     = '0;
    logic               i_out_stall   = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [KIND_W-1:0]  o_item_kind;
    logic [VALUE_W-1:0] o_item_value;
    logic [INDEX_W-1:0] o_item_index;

    logic [VALUE_W-1:0] rx_bytes_pending [$];
    t_parsed_item       parsed_items_due [$];
    int unsigned        bytes_queued  = 0;
    int unsigned        bytes_taken   = 0;
    int unsigned        tx_idle_pct   = 0;
    int unsigned        rx_stall_pct  = 0;
    bit                 rx_hold_req   = 1'b0;
    int unsigned        rx_hold_count = 0;
    int unsigned        cycle_count   = 0;
    bit                 mismatch_seen = 1'b0;

    t_parse_state       parse_st    = ST_IDLE;
    int unsigned        field_pos   = 0;
    logic               accept_high = 1'b0;

    escape_framed_udp_deframer #(
        .SMALL_LEN(SMALL_LEN)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_item_kind   (o_item_kind),
        .o_item_value  (o_item_value),
        .o_item_index  (o_item_index)
    );

    always #5ns i_clk = ~i_clk;

    function automatic bit is_printable(input logic [VALUE_W-1:0] b);
        if (b >= 8'd128) begin
            return accept_high;
        end
        return b >= CH_SPACE;
    endfunction

    function automatic void advance_pos();
        if (field_pos < SMALL_LEN - 1) begin
            field_pos++;
        end
    endfunction

    task automatic parse_byte(input logic [VALUE_W-1:0] b);
        t_parsed_item r;
        bit           hit;
        hit = 1'b0;
        case (parse_st)
            ST_IDLE: begin
                if (b == CH_ESC) begin
                    parse_st = ST_ESC;
                end
            end
            ST_ESC: begin
                parse_st = (b == CH_START) ? ST_CID : ST_SKIP;
            end
            ST_CID: begin
                field_pos = 0;
                parse_st  = ST_ADDR;
                r         = '{KIND_CID, b, '0};
                hit       = 1'b1;
            end
            ST_ADDR: begin
                if (b == CH_ESC) begin
                    parse_st = ST_IDLE;
                end else if (b == CH_SPACE) begin
                    r         = '{KIND_ADDR_END, '0, field_pos[INDEX_W-1:0]};
                    hit       = 1'b1;
                    field_pos = 0;
                    parse_st  = ST_PORT;
                end else if (is_printable(b)) begin
                    r   = '{KIND_ADDR_CHAR, b, field_pos[INDEX_W-1:0]};
                    hit = 1'b1;
                    advance_pos();
                end
            end
            ST_PORT: begin
                if (b == CH_ESC) begin
                    parse_st = ST_IDLE;
                end else if (b == CH_TAB) begin
                    r         = '{KIND_PORT_END, '0, field_pos[INDEX_W-1:0]};
                    hit       = 1'b1;
                    field_pos = 0;
                    parse_st  = ST_DATA;
                end else if (is_printable(b)) begin
                    r   = '{KIND_PORT_CHAR, b, field_pos[INDEX_W-1:0]};
                    hit = 1'b1;
                    advance_pos();
                end
            end
            ST_DATA: begin
                if (b == CH_ESC) begin
                    parse_st = ST_CLOSE;
                end else if (is_printable(b)) begin
                    r   = '{KIND_DATA_CHAR, b, field_pos[INDEX_W-1:0]};
                    hit = 1'b1;
                    advance_pos();
                end
            end
            ST_CLOSE: begin
                parse_st = ST_IDLE;
                r        = '{KIND_DONE, '0, field_pos[INDEX_W-1:0]};
                hit      = 1'b1;
            end
            default: begin
                parse_st = ST_IDLE;
            end
        endcase
        if (hit) begin
            parsed_items_due.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin : byte_driver
        bit taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            taken = i_in_valid && !o_in_stall;
            if (taken) begin
                parse_byte(i_rx_byte);
                bytes_taken++;
            end
            if (i_in_valid && !taken) begin
                // The stalled word stays on the bus unchanged.
            end else if (rx_bytes_pending.size() > 0 &&
                         $urandom_range(0, 99) >= tx_idle_pct) begin
                i_in_valid <= 1'b1;
                i_rx_byte  <= rx_bytes_pending.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_parsed_item e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (parsed_items_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, %s %0d value %0d index %0d",
                             $time, "actual kind", o_item_kind, o_item_value,
                             o_item_index);
                    mismatch_seen = 1'b1;
                end else begin
                    e = parsed_items_due.pop_front();
                    if (o_item_kind !== e.kind || o_item_value !== e.value ||
                        o_item_index !== e.index) begin
                        $display({"%0t: mismatch, expected kind %0d value %0d index %0d, ",
                                  "actual kind %0d value %0d index %0d"},
                                 $time, e.kind, e.value, e.index,
                                 o_item_kind, o_item_value, o_item_index);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            if (rx_hold_req && rx_hold_count < HOLD_CYCLES) begin
                rx_hold_count++;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
            end
        end
    end

    task automatic send(input logic [VALUE_W-1:0] b);
        rx_bytes_pending.push_back(b);
        bytes_queued++;
    endtask

    function automatic int unsigned field_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(25, 40);
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [VALUE_W-1:0] field_char(input logic [VALUE_W-1:0] stop);
        logic [VALUE_W-1:0] c;
        do begin
            case ($urandom_range(0, 9))
                0:       c = 8'($urandom_range(0, 31));
                1:       c = 8'($urandom_range(128, 255));
                default: c = 8'($urandom_range(32, 127));
            endcase
        end while (c == CH_ESC || c == stop);
        return c;
    endfunction

    task automatic send_field(input logic [VALUE_W-1:0] stop);
        int unsigned n;
        n = field_len();
        repeat (n) send(field_char(stop));
    endtask

    task automatic send_frame_head();
        send(CH_ESC);
        send(CH_START);
        send(8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_bytes(input int unsigned count);
        int unsigned        target;
        logic [VALUE_W-1:0] b;
        target = bytes_queued + count;
        while (bytes_queued < target) begin
            case ($urandom_range(0, 9))
                7: begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_START);
                    send(CH_ESC);
                    send(b);
                    send(8'($urandom_range(0, 255)));
                end
                8: begin
                    send_frame_head();
                    send_field(CH_SPACE);
                    if ($urandom_range(0, 1)) begin
                        send(CH_SPACE);
                        send_field(CH_TAB);
                    end
                    send(CH_ESC);
                end
                9: begin
                    repeat ($urandom_range(1, 6)) send(8'($urandom_range(0, 255)));
                end
                default: begin
                    send_frame_head();
                    send_field(CH_SPACE);
                    send(CH_SPACE);
                    send_field(CH_TAB);
                    send(CH_TAB);
                    send_field(CH_ESC);
                    send(CH_ESC);
                    send(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || parsed_items_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_accept_high(input logic v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        accept_high = v;
    endtask

    task automatic run_phase(input logic cfg, input int unsigned tx_pct,
                             input int unsigned rx_pct, input int unsigned count);
        set_accept_high(cfg);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        add_random_bytes(count);
        wait_drained();
    endtask

    initial begin : timeout_guard
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_accept_high(1'b0);

        // Full frame with a tab and a high byte dropped from the address, spaces
        // inside port and data, a control byte dropped from the data.
        send(CH_ESC); send(CH_START); send(8'hFF); send("1"); send(CH_TAB);
        send(8'h80); send(CH_SPACE); send("8"); send(CH_SPACE); send(CH_TAB);
        send("h"); send(CH_SPACE); send(8'h1F); send(CH_ESC); send(8'h00);
        // A byte other than the start code after an escape makes the parser skip one byte.
        send(CH_ESC); send("x"); send(CH_ESC);
        // An escape in the address and then in the port aborts the frame.
        send(CH_ESC); send(CH_START); send(8'h00); send("a"); send(CH_ESC);
        send(CH_ESC); send(CH_START); send("c"); send(CH_SPACE); send("9");
        send(CH_ESC);
        wait_drained();

        set_accept_high(1'b1);
        add_random_bytes(100);
        wait_drained();
        add_random_bytes(100);
        wait_drained();

        run_phase(1'b0, 87, 0, 200);
        run_phase(1'b1, 0, 87, 200);
        run_phase(1'b0, 34, 34, 200);
        rx_hold_req = 1'b1;
        run_phase(1'b1, 0, 0, 200);

        if (!mismatch_seen) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
